// File: hw/rtl/yrpi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package yrpi_pkg;

  localparam int RATE_W     = 16;
  localparam int ERR_W      = 17;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int SPEED_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_RATE = 3'd0,
    CFG_PROP_GAIN   = 3'd1,
    CFG_INTEG_GAIN  = 3'd2,
    CFG_MAX_STEER   = 3'd3,
    CFG_KICKIN_BAND = 3'd4,
    CFG_CRUISE      = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic load_err;
    logic accum;
    logic div_init;
    logic div_step;
    logic clamp;
    logic mul_init;
    logic mul_step;
    logic out_load;
  } yrpi_cmd_t;

  typedef struct packed {
    logic integ_gain_zero;
  } yrpi_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/yrpi_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface yrpi_in_if;
  import yrpi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] measured_rate;
  modport source (output valid, output measured_rate, input ready);
  modport sink   (input valid, input measured_rate, output ready);
endinterface

interface yrpi_out_if;
  import yrpi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] steer_angle;
  logic [SPEED_W-1:0]       speed_cmd;
  logic                     integ_clamped;
  modport source (output valid, output steer_angle, output speed_cmd, output integ_clamped,
                  input ready);
  modport sink   (input valid, input steer_angle, input speed_cmd, input integ_clamped,
                  output ready);
endinterface

interface yrpi_cfg_if;
  import yrpi_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/yrpi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module yrpi_ctrl #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire yrpi_pkg::yrpi_status_t status,
  output yrpi_pkg::yrpi_cmd_t        cmd
);
  import yrpi_pkg::*;

  localparam int DIV_W = LIM_W + GAIN_FRAC_BITS;
  localparam int MAX_STEPS = (DIV_W > GAIN_W) ? DIV_W : GAIN_W;
  localparam int CNT_W = $clog2(MAX_STEPS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(GAIN_W - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ACC   = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_CLAMP = 7'b0001000,
    S_MINIT = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_err = 1'b1;
          state_next   = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accum    = 1'b1;
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = status.integ_gain_zero ? S_MINIT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_MINIT;
      end
      S_MINIT: begin
        cmd.mul_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/yrpi_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module yrpi_dp #(
  parameter int INTEG_WIDTH    = 24,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  input  wire logic [yrpi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [yrpi_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic signed [yrpi_pkg::RATE_W-1:0]   measured_rate,
  input  wire yrpi_pkg::yrpi_cmd_t                  cmd,
  output yrpi_pkg::yrpi_status_t                    status,
  output logic signed [yrpi_pkg::RATE_W-1:0]        steer_angle,
  output logic [yrpi_pkg::SPEED_W-1:0]              speed_cmd,
  output logic                                      integ_clamped
);
  import yrpi_pkg::*;

  localparam int IW    = INTEG_WIDTH;
  localparam int DIV_W = LIM_W + GAIN_FRAC_BITS;
  localparam int PW    = IW + 18;
  localparam int CW    = ((IW > DIV_W) ? IW : DIV_W) + 2;
  localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};
  localparam logic signed [PW-1:0] SMAX = PW'(32767);
  localparam logic signed [PW-1:0] SMIN = PW'(-32768);

  // configuration registers
  logic signed [RATE_W-1:0] target_rate;
  logic [GAIN_W-1:0]        prop_gain;
  logic [GAIN_W-1:0]        integ_gain;
  logic [LIM_W-1:0]         max_integ_steer;
  logic [LIM_W-1:0]         kickin_band;
  logic [SPEED_W-1:0]       cruise_speed;

  logic signed [ERR_W-1:0] err;
  logic signed [IW-1:0]    integ;
  logic                    clamped;
  logic [GAIN_W-1:0]       div_rem;
  logic [DIV_W-1:0]        div_quo;
  logic signed [PW-1:0]    mul_acc;
  logic signed [PW-1:0]    mp_cand;
  logic signed [PW-1:0]    mi_cand;
  logic [GAIN_W-1:0]       mp_gain;
  logic [GAIN_W-1:0]       mi_gain;

  logic [ERR_W-1:0]        mag;
  logic signed [IW:0]      sum;
  logic signed [IW-1:0]    sum_sat;
  logic [GAIN_W:0]         rem_sh;
  logic                    rem_ge;
  logic signed [CW-1:0]    lim;
  logic signed [CW-1:0]    acc_ext;
  logic signed [PW-1:0]    mul_next;
  logic signed [PW-1:0]    shifted;
  logic signed [RATE_W-1:0] steer_sat;

  assign status.integ_gain_zero = (integ_gain == '0);

  always_comb begin
    mag     = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    sum     = (IW+1)'(integ) + (IW+1)'(err);
    if (sum[IW] != sum[IW-1]) begin
      sum_sat = sum[IW] ? IMIN : IMAX;
    end else begin
      sum_sat = sum[IW-1:0];
    end
    rem_sh  = {div_rem, div_quo[DIV_W-1]};
    rem_ge  = (rem_sh >= {1'b0, integ_gain});
    lim     = $signed({{(CW-DIV_W){1'b0}}, div_quo});
    acc_ext = CW'(integ);
    mul_next = mul_acc + (mp_gain[0] ? mp_cand : '0) + (mi_gain[0] ? mi_cand : '0);
    shifted = mul_acc >>> GAIN_FRAC_BITS;
    if (shifted > SMAX) begin
      steer_sat = RATE_W'(SMAX);
    end else if (shifted < SMIN) begin
      steer_sat = RATE_W'(SMIN);
    end else begin
      steer_sat = shifted[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_rate     <= '0;
      prop_gain       <= '0;
      integ_gain      <= '0;
      max_integ_steer <= '0;
      kickin_band     <= '0;
      cruise_speed    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TARGET_RATE: target_rate     <= cfg_data;
        CFG_PROP_GAIN:   prop_gain       <= cfg_data;
        CFG_INTEG_GAIN:  integ_gain      <= cfg_data;
        CFG_MAX_STEER:   max_integ_steer <= cfg_data[LIM_W-1:0];
        CFG_KICKIN_BAND: kickin_band     <= cfg_data[LIM_W-1:0];
        CFG_CRUISE:      cruise_speed    <= cfg_data;
        default: ;
      endcase
    end
  end

  // integral state
  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
    end else if (cmd.accum) begin
      integ <= (mag < {2'b00, kickin_band}) ? '0 : sum_sat;
    end else if (cmd.clamp) begin
      if (acc_ext > lim) begin
        integ <= lim[IW-1:0];
      end else if (acc_ext < -lim) begin
        integ <= IW'(-lim);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      err <= ERR_W'(target_rate) - ERR_W'(measured_rate);
    end
    if (cmd.accum) begin
      clamped <= 1'b0;
    end else if (cmd.clamp) begin
      clamped <= (acc_ext > lim) || (acc_ext < -lim);
    end
    // restoring divider for the clamp limit
    if (cmd.div_init) begin
      div_rem <= '0;
      div_quo <= DIV_W'(max_integ_steer) << GAIN_FRAC_BITS;
    end else if (cmd.div_step) begin
      div_rem <= rem_ge ? GAIN_W'(rem_sh - {1'b0, integ_gain}) : rem_sh[GAIN_W-1:0];
      div_quo <= {div_quo[DIV_W-2:0], rem_ge};
    end
    // shift-add multiply of both terms
    if (cmd.mul_init) begin
      mul_acc <= '0;
      mp_cand <= PW'(err);
      mi_cand <= PW'(integ);
      mp_gain <= prop_gain;
      mi_gain <= integ_gain;
    end else if (cmd.mul_step) begin
      mul_acc <= mul_next;
      mp_cand <= mp_cand <<< 1;
      mi_cand <= mi_cand <<< 1;
      mp_gain <= mp_gain >> 1;
      mi_gain <= mi_gain >> 1;
    end
    if (cmd.out_load) begin
      steer_angle   <= steer_sat;
      speed_cmd     <= cruise_speed;
      integ_clamped <= clamped;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/yaw_rate_pi_controller.sv
// channel   dir  handshake      payload
// in_ch     in   valid/ready    measured_rate
// out_ch    out  valid/ready    steer_angle, speed_cmd, integ_clamped
// cfg       in   valid/ready    index, data
//
// one item at a time: after the input transfer the item passes the accumulate, bit-serial
// limit divide, clamp, multiply-init and 16-step shift-add multiply states before the valid
// result is loaded and the next input is taken; divider and clamp skipped at integ_gain 0
// a finished result waits in the output register while the next item is taken
// synchronous reset clears configuration, integral and handshake state
// cfg is always ready; writes belong to idle periods
`timescale 1ns / 1ps
`default_nettype none

module yaw_rate_pi_controller #(
  parameter int INTEG_WIDTH    = 24,
  parameter int GAIN_FRAC_BITS = 8
) (
  input wire logic   clk,
  input wire logic   rst,
  yrpi_in_if.sink    in_ch,
  yrpi_out_if.source out_ch,
  yrpi_cfg_if.sink   cfg
);
  import yrpi_pkg::*;

  yrpi_cmd_t    cmd;
  yrpi_status_t status;

  assign cfg.ready = 1'b1;

  yrpi_ctrl #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  yrpi_dp #(
    .INTEG_WIDTH   (INTEG_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .measured_rate (in_ch.measured_rate),
    .cmd           (cmd),
    .status        (status),
    .steer_angle   (out_ch.steer_angle),
    .speed_cmd     (out_ch.speed_cmd),
    .integ_clamped (out_ch.integ_clamped)
  );

endmodule

`default_nettype wire

// File: hw/rtl/yrpi_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module yrpi_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [yrpi_pkg::RATE_W-1:0]  steer_angle,
  input wire logic [yrpi_pkg::SPEED_W-1:0]        speed_cmd,
  input wire logic                                integ_clamped
);
  import yrpi_pkg::*;

  // result held until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(steer_angle) && $stable(speed_cmd) && $stable(integ_clamped))
    else $error("result payload changed while stalled");

  // only one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  // no result right after input transfer
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after input");

endmodule

bind yaw_rate_pi_controller yrpi_checker u_yrpi_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .steer_angle   (out_ch.steer_angle),
  .speed_cmd     (out_ch.speed_cmd),
  .integ_clamped (out_ch.integ_clamped)
);

`default_nettype wire
